### rtl/core/window_line_fit_intercept_core_macros.svh
// Assertion macros for the window line fit core.
// Used by the back-end module; relies on clk and arst_n in scope.
`ifndef WINDOW_LINE_FIT_INTERCEPT_CORE_MACROS_SVH
`define WINDOW_LINE_FIT_INTERCEPT_CORE_MACROS_SVH

// same-cycle implication
`define WLF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wlf assertion failed");

// next-cycle implication
`define WLF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wlf assertion failed");

`endif

### rtl/core/wlf_pkg.sv
// Shared types and constants for the window line fit core.
// No dependencies.
`default_nettype none
package wlf_pkg;
	localparam int MAX_WINDOW = 16;
	localparam int IDX_W      = $clog2(MAX_WINDOW);
	localparam int LEN_W      = 5;
	localparam int Q_DEPTH    = 2;
	localparam int QP_W       = $clog2(Q_DEPTH);
	localparam int DVD_W      = 62;
	localparam int DVS_W      = 47;
	localparam int DCNT_W     = $clog2(DVD_W + 1);

	localparam logic [LEN_W-1:0] MIN_LEN     = LEN_W'(2);
	localparam logic [LEN_W-1:0] RESET_LEN   = LEN_W'(5);
	localparam logic [15:0]      RESET_TRAVEL = 16'(100 * 16);

	typedef enum logic [2:0] {
		ST_FILL   = 3'd0,
		ST_REJECT = 3'd1,
		ST_FLAT   = 3'd2,
		ST_FIT    = 3'd3,
		ST_VERT   = 3'd4
	} status_t;

	typedef enum logic {
		REG_WINDOW_LEN = 1'b0,
		REG_MIN_TRAVEL = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_TRAVEL, S_SUM, S_PROD, S_DIFF, S_CLASS, S_MUL,
		S_SIGN, S_SIGN2, S_DIVGO, S_DIVWAIT, S_SAT, S_OUT
	} back_state_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
	} point_t;

	typedef struct packed {
		status_t            status;
		logic signed [15:0] target;
	} result_t;
endpackage
`default_nettype wire

### rtl/core/wlf_front.sv
// Front end: accepts points and holds them in a short queue for the back end.
// Depends on wlf_pkg.
`default_nettype none
module wlf_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wlf_pkg::point_t    in_point,
	output logic               out_valid,
	input  wire logic          out_ready,
	output wlf_pkg::point_t    out_point
);
	import wlf_pkg::*;

	point_t            buf_q [Q_DEPTH];
	logic [QP_W-1:0]   wptr_q, rptr_q;
	logic [QP_W:0]     count_q;
	logic              push, pop;

	assign in_ready  = count_q != (QP_W+1)'(Q_DEPTH);
	assign out_valid = count_q != '0;
	assign out_point = buf_q[rptr_q];
	assign push      = in_valid & in_ready;
	assign pop       = out_valid & out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wptr_q] <= in_point;
	end
endmodule
`default_nettype wire

### rtl/core/wlf_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on wlf_pkg.
`default_nettype none
module wlf_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [wlf_pkg::DVD_W-1:0]  dividend,
	input  wire logic [wlf_pkg::DVS_W-1:0]  divisor,
	output logic                            done,
	output logic [wlf_pkg::DVD_W-1:0]       quotient
);
	import wlf_pkg::*;

	logic [DVS_W-1:0]  dvs_q, rem_q, rem_next;
	logic [DVD_W-1:0]  quo_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q, done_q, ge;
	logic [DVS_W:0]    rem_sh, diff;

	assign rem_sh   = {rem_q, quo_q[DVD_W-1]};
	assign diff     = rem_sh - {1'b0, dvs_q};
	assign ge       = rem_sh >= {1'b0, dvs_q};
	assign rem_next = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end
endmodule
`default_nettype wire

### rtl/core/wlf_back.sv
// Back end: window store, running sums, fit and intercept sequencer.
// Depends on wlf_pkg, wlf_div and the assertion macro header.
`default_nettype none
`include "window_line_fit_intercept_core_macros.svh"
module wlf_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      q_valid,
	output logic                           q_ready,
	input  wlf_pkg::point_t                q_point,
	input  wire logic [wlf_pkg::LEN_W-1:0] win_len,
	input  wire logic [15:0]               min_travel,
	output logic                           res_valid,
	input  wire logic                      res_ready,
	output wlf_pkg::result_t               res
);
	import wlf_pkg::*;

	back_state_t state_q, state_d;

	point_t             mem [MAX_WINDOW];
	point_t             rd_q, pt_q;
	logic [LEN_W-1:0]   n_eff, n_q, fill_q, cnt_q, fill_adj, fill_ext;
	logic [IDX_W-1:0]   oldest_q, oldest_new, raddr, waddr;
	logic               pop, issue, sum_done, div_start, div_done;
	logic               v_rd_q, v_pr_q, pp_v_s1, pp_hi_s1, pp_sub_s1;
	logic [2:0]         mstep_q;

	logic signed [16:0] dx, dy;
	logic [16:0]        adx, ady;
	logic [17:0]        travel;
	logic               reject;

	logic signed [15:0] x_s1, y_s1;
	logic signed [31:0] xx_s1, xy_s1;
	logic signed [21:0] sx_q, sy_q;
	logic signed [37:0] sxx_q, sxy_q;
	logic signed [43:0] p1_s2, p2_s2, p3_s2, p4_s2, d_q, nn_q;
	logic [43:0]        nn_abs;
	logic [48:0]        den_full;
	logic [45:0]        den_q;
	logic [21:0]        sx_abs;

	logic signed [22:0] op_a, op_b;
	logic signed [45:0] pp_s1;
	logic signed [63:0] acc_q, term, acc_abs;
	logic [60:0]        mag_q;
	logic               neg_q;

	logic [DVD_W-1:0]   div_a_q, quo;
	logic [DVS_W-1:0]   div_b_q;
	logic [16:0]        negq;
	status_t            status_q;
	logic signed [15:0] target_q;

	wlf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a_q),
		.divisor  (div_b_q),
		.done     (div_done),
		.quotient (quo)
	);

	// effective window length, clamped to 2..MAX_WINDOW
	always_comb begin
		if (win_len < MIN_LEN) n_eff = MIN_LEN;
		else if (win_len > LEN_W'(MAX_WINDOW)) n_eff = LEN_W'(MAX_WINDOW);
		else n_eff = win_len;
	end

	// drop the oldest points so that the new one makes at most n
	always_comb begin
		fill_ext = fill_q - n_eff + 1'b1;
		if (fill_q >= n_eff) begin
			oldest_new = oldest_q + fill_ext[IDX_W-1:0];
			fill_adj   = n_eff - 1'b1;
		end else begin
			oldest_new = oldest_q;
			fill_adj   = fill_q;
		end
		waddr = oldest_new + fill_adj[IDX_W-1:0];
	end

	always_comb begin
		dx     = {pt_q.x[15], pt_q.x} - {rd_q.x[15], rd_q.x};
		dy     = {pt_q.y[15], pt_q.y} - {rd_q.y[15], rd_q.y};
		adx    = dx[16] ? 17'(-dx) : 17'(dx);
		ady    = dy[16] ? 17'(-dy) : 17'(dy);
		travel = {1'b0, adx} + {1'b0, ady};
		reject = (!dy[16] && dy != '0) || (travel < {2'b00, min_travel});
	end

	always_comb begin
		nn_abs   = nn_q[43] ? 44'(-nn_q) : 44'(nn_q);
		den_full = n_q * nn_abs;
		sx_abs   = sx_q[21] ? 22'(-sx_q) : 22'(sx_q);
		acc_abs  = acc_q[63] ? -acc_q : acc_q;
		negq     = 17'd0 - quo[16:0];
	end

	// partial-product operands: N*Sx then D*Sy, low and high halves
	always_comb begin
		case (mstep_q)
			3'd0: begin op_a = {1'b0, nn_q[21:0]}; op_b = {sx_q[21], sx_q}; end
			3'd1: begin op_a = {nn_q[43], nn_q[43:22]}; op_b = {sx_q[21], sx_q}; end
			3'd2: begin op_a = {1'b0, d_q[21:0]}; op_b = {sy_q[21], sy_q}; end
			3'd3: begin op_a = {d_q[43], d_q[43:22]}; op_b = {sy_q[21], sy_q}; end
			default: begin op_a = '0; op_b = '0; end
		endcase
		term = pp_hi_s1 ? (64'(pp_s1) <<< 22) : 64'(pp_s1);
	end

	// control outputs
	always_comb begin
		q_ready   = state_q == S_IDLE;
		pop       = q_valid && q_ready;
		res_valid = state_q == S_OUT;
		div_start = state_q == S_DIVGO;
		issue     = (state_q == S_SUM) && (cnt_q < n_q);
		sum_done  = (state_q == S_SUM) && !issue && !v_rd_q && !v_pr_q;
		raddr     = (state_q == S_LOAD) ? oldest_q : oldest_q + cnt_q[IDX_W-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:    if (q_valid) state_d = S_LOAD;
			S_LOAD:    state_d = (fill_q < n_q) ? S_OUT : S_TRAVEL;
			S_TRAVEL:  state_d = reject ? S_OUT : S_SUM;
			S_SUM:     if (sum_done) state_d = S_PROD;
			S_PROD:    state_d = S_DIFF;
			S_DIFF:    state_d = S_CLASS;
			S_CLASS: begin
				if (d_q == '0) state_d = S_DIVGO;
				else if (nn_q == '0) state_d = S_OUT;
				else state_d = S_MUL;
			end
			S_MUL:     if (mstep_q == 3'd5) state_d = S_SIGN;
			S_SIGN:    state_d = S_SIGN2;
			S_SIGN2:   state_d = S_DIVGO;
			S_DIVGO:   state_d = S_DIVWAIT;
			S_DIVWAIT: if (div_done) state_d = S_SAT;
			S_SAT:     state_d = S_OUT;
			S_OUT:     if (res_ready) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			oldest_q <= '0;
			cnt_q    <= '0;
			v_rd_q   <= 1'b0;
			v_pr_q   <= 1'b0;
			mstep_q  <= '0;
			pp_v_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				fill_q   <= fill_adj + 1'b1;
				oldest_q <= oldest_new;
			end
			if (state_q == S_TRAVEL) begin
				cnt_q  <= '0;
				v_rd_q <= 1'b0;
				v_pr_q <= 1'b0;
				if (reject) begin
					fill_q   <= '0;
					oldest_q <= '0;
				end
			end
			if (state_q == S_SUM) begin
				if (issue) cnt_q <= cnt_q + 1'b1;
				v_rd_q <= issue;
				v_pr_q <= v_rd_q;
			end
			if (state_q == S_CLASS) mstep_q <= '0;
			if (state_q == S_MUL) begin
				if (mstep_q != 3'd5) mstep_q <= mstep_q + 1'b1;
				pp_v_s1 <= mstep_q < 3'd4;
			end else begin
				pp_v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mem[waddr] <= q_point;
			pt_q       <= q_point;
			n_q        <= n_eff;
		end
		rd_q <= mem[raddr];

		if (state_q == S_LOAD) begin
			status_q <= ST_FILL;
			target_q <= '0;
		end
		if (state_q == S_TRAVEL) begin
			sx_q  <= '0;
			sy_q  <= '0;
			sxx_q <= '0;
			sxy_q <= '0;
			if (reject) begin
				status_q <= ST_REJECT;
				target_q <= '0;
			end
		end
		if (state_q == S_SUM) begin
			if (v_rd_q) begin
				x_s1  <= rd_q.x;
				y_s1  <= rd_q.y;
				xx_s1 <= rd_q.x * rd_q.x;
				xy_s1 <= rd_q.x * rd_q.y;
			end
			if (v_pr_q) begin
				sx_q  <= sx_q + {{6{x_s1[15]}}, x_s1};
				sy_q  <= sy_q + {{6{y_s1[15]}}, y_s1};
				sxx_q <= sxx_q + {{6{xx_s1[31]}}, xx_s1};
				sxy_q <= sxy_q + {{6{xy_s1[31]}}, xy_s1};
			end
		end
		if (state_q == S_PROD) begin
			p1_s2 <= $signed({1'b0, n_q}) * sxx_q;
			p2_s2 <= sx_q * sx_q;
			p3_s2 <= $signed({1'b0, n_q}) * sxy_q;
			p4_s2 <= sx_q * sy_q;
		end
		if (state_q == S_DIFF) begin
			d_q  <= p1_s2 - p2_s2;
			nn_q <= p3_s2 - p4_s2;
		end
		if (state_q == S_CLASS) begin
			acc_q <= '0;
			den_q <= den_full[45:0];
			if (d_q == '0) begin
				// vertical: rounded mean x
				status_q <= ST_VERT;
				neg_q    <= sx_q[21];
				div_a_q  <= DVD_W'({sx_abs, 1'b0}) + DVD_W'(n_q);
				div_b_q  <= DVS_W'({n_q, 1'b0});
			end else if (nn_q == '0) begin
				status_q <= ST_FLAT;
				target_q <= '0;
			end else begin
				status_q <= ST_FIT;
			end
		end
		if (state_q == S_MUL) begin
			pp_s1     <= op_a * op_b;
			pp_hi_s1  <= mstep_q[0];
			pp_sub_s1 <= mstep_q[1];
			if (pp_v_s1) acc_q <= pp_sub_s1 ? acc_q - term : acc_q + term;
		end
		if (state_q == S_SIGN) begin
			neg_q <= acc_q[63] ^ nn_q[43];
			mag_q <= acc_abs[60:0];
		end
		if (state_q == S_SIGN2) begin
			div_a_q <= DVD_W'({mag_q, 1'b0}) + DVD_W'(den_q);
			div_b_q <= {den_q, 1'b0};
		end
		if (state_q == S_SAT) begin
			if (!neg_q) target_q <= (quo > DVD_W'(32767)) ? 16'sh7FFF : quo[15:0];
			else target_q <= (quo > DVD_W'(32768)) ? 16'sh8000 : negq[15:0];
		end
	end

	assign res.status = status_q;
	assign res.target = target_q;

	`WLF_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= LEN_W'(MAX_WINDOW))
	`WLF_ASSERT_NEXT(a_pop_to_load, pop, state_q == S_LOAD)
	`WLF_ASSERT_NOW(a_zero_target, res_valid && (status_q == ST_FILL || status_q == ST_REJECT || status_q == ST_FLAT), target_q == '0)
endmodule
`default_nettype wire

### rtl/core/window_line_fit_intercept_core.sv
// Sliding-window least-squares line fit with x-intercept prediction.
// Points enter on the point channel (valid/ready); one result per point
// leaves on the result channel (valid/ready) with a status and target_x.
// Configuration: cfg_we writes cfg_wdata into register cfg_index
// (window_len, min_travel) at once; write only while the block is idle.
// Path from point acceptance to result_valid: while the window fills the
// result follows the load, a rejected point goes out after the travel check,
// a flat track after the window sum loop (one stored point per cycle) and the
// products; a vertical track adds the bit-serial divider, and a fitted point a
// serial multiply and then the divider. One point is worked on at a time; the
// back end takes the next queued point in the cycle after a result handoff.
// A two-entry input queue keeps accepting while the back end is busy,
// and the result register holds a finished transaction while the receiver
// stalls; the back end waits until that register frees up.
// Reset clears the window (fill count and oldest slot), loads window_len 5
// and min_travel 1600, and empties the queue and result register.
// Depends on wlf_pkg, wlf_front, wlf_back.
`default_nettype none
module window_line_fit_intercept_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               point_valid,
	output logic                    point_ready,
	input  wire logic signed [15:0] point_x,
	input  wire logic signed [15:0] point_y,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output logic [2:0]              status,
	output logic signed [15:0]      target_x,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [15:0]        cfg_wdata
);
	import wlf_pkg::*;

	logic [LEN_W-1:0] win_len_q;
	logic [15:0]      min_travel_q;
	point_t           in_point, q_point;
	logic             q_valid, q_ready;
	logic             res_valid, res_ready;
	result_t          res, out_q;
	logic             out_valid_q;

	assign in_point.x = point_x;
	assign in_point.y = point_y;

	wlf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (point_valid),
		.in_ready  (point_ready),
		.in_point  (in_point),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_point (q_point)
	);

	wlf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_ready    (q_ready),
		.q_point    (q_point),
		.win_len    (win_len_q),
		.min_travel (min_travel_q),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	assign res_ready    = !out_valid_q || result_ready;
	assign result_valid = out_valid_q;
	assign status       = out_q.status;
	assign target_x     = out_q.target;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q    <= RESET_LEN;
			min_travel_q <= RESET_TRAVEL;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_WINDOW_LEN) win_len_q <= cfg_wdata[LEN_W-1:0];
				else min_travel_q <= cfg_wdata;
			end
			if (res_ready) out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) out_q <= res;
	end
endmodule
`default_nettype wire
